// File: sv/tmrn_pkg.sv
// ----------------------------------------------------------------------------
// tmrn_pkg
// Shared types and constants of the tree map/reduce node: message kinds,
// status codes, register indexes and the command passed from front to back.
// ----------------------------------------------------------------------------
package tmrn_pkg;

  localparam int MAX_FANOUT  = 16;
  localparam int ID_WIDTH    = 32;
  localparam int DEPTH_WIDTH = 8;
  localparam int FAN_WIDTH   = 5;
  localparam int IDX_WIDTH   = $clog2(MAX_FANOUT);
  localparam int KIND_WIDTH  = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [ID_WIDTH-1:0]  ROOT_ID      = 32'd1;
  localparam logic [FAN_WIDTH-1:0] FAN_MAX      = FAN_WIDTH'(MAX_FANOUT);

  localparam logic                 ACTION_START = 1'b0;

  localparam logic [KIND_WIDTH-1:0] MSG_MAP     = 8'd1;
  localparam logic [KIND_WIDTH-1:0] MSG_REDUCE  = 8'd2;

  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_MAP    = 2'd1;
  localparam logic [1:0] OUT_REDUCE = 2'd2;

  localparam logic [1:0] ST_SENT    = 2'd0;
  localparam logic [1:0] ST_NOTHING = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_OUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_DEPTH = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [ID_WIDTH-1:0]    base;
    logic [DEPTH_WIDTH-1:0] depth_limit;
    logic [DEPTH_WIDTH-1:0] depth_now;
    logic [ID_WIDTH-1:0]    sender;
    logic [1:0]             status;
    logic                   mismatch;
    logic [FAN_WIDTH-1:0]   count;
  } cmd_t;

endpackage

// File: sv/tmrn_front.sv
// ----------------------------------------------------------------------------
// tmrn_front
// Accepts items, holds configuration and node state, and turns each item
// into one command: a run of count results with targets base, base+1, ...
// ----------------------------------------------------------------------------
module tmrn_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmrn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmrn_pkg::ID_WIDTH-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [tmrn_pkg::KIND_WIDTH-1:0]    message_kind,
  input  logic [tmrn_pkg::ID_WIDTH-1:0]      target_node,
  input  logic [tmrn_pkg::DEPTH_WIDTH-1:0]   depth_limit,
  input  logic [tmrn_pkg::DEPTH_WIDTH-1:0]   depth_now,
  input  logic [tmrn_pkg::ID_WIDTH-1:0]      sender_node,
  input  logic                               q_full,
  output logic                               q_push,
  output tmrn_pkg::cmd_t                     q_cmd
);

  logic [tmrn_pkg::ID_WIDTH-1:0]    own_id;
  logic [tmrn_pkg::FAN_WIDTH-1:0]   fan_out;
  logic [tmrn_pkg::DEPTH_WIDTH-1:0] root_limit;
  logic [tmrn_pkg::ID_WIDTH-1:0]    parent_node;
  logic [tmrn_pkg::ID_WIDTH-1:0]    parent_node_next;
  logic [tmrn_pkg::FAN_WIDTH-1:0]   answers_seen;
  logic [tmrn_pkg::FAN_WIDTH-1:0]   answers_seen_next;
  logic                             finished;
  logic                             finished_next;
  logic [tmrn_pkg::FAN_WIDTH-1:0]   fan_eff;
  logic [tmrn_pkg::ID_WIDTH-1:0]    fan_wide;
  logic [tmrn_pkg::ID_WIDTH-1:0]    child_base;
  logic                             accept;
  tmrn_pkg::cmd_t                   cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && !q_full;
  assign q_push    = accept;
  assign q_cmd     = cmd;

  always_comb begin
    if (fan_out == '0) begin
      fan_eff = tmrn_pkg::FAN_WIDTH'(1);
    end else if (fan_out > tmrn_pkg::FAN_MAX) begin
      fan_eff = tmrn_pkg::FAN_MAX;
    end else begin
      fan_eff = fan_out;
    end
  end

  assign fan_wide   = tmrn_pkg::ID_WIDTH'(fan_eff);
  assign child_base = tmrn_pkg::ID_WIDTH'(own_id * fan_wide) - fan_wide
                      + tmrn_pkg::ID_WIDTH'(2);

  always_comb begin
    cmd               = '0;
    cmd.kind          = tmrn_pkg::OUT_NONE;
    cmd.status        = tmrn_pkg::ST_NOTHING;
    cmd.count         = tmrn_pkg::FAN_WIDTH'(1);
    parent_node_next  = parent_node;
    answers_seen_next = answers_seen;
    finished_next     = finished;
    if (finished) begin
      cmd.status = tmrn_pkg::ST_IGNORED;
    end else if (action == tmrn_pkg::ACTION_START) begin
      if (own_id == tmrn_pkg::ROOT_ID) begin
        cmd.kind        = tmrn_pkg::OUT_MAP;
        cmd.base        = child_base;
        cmd.depth_limit = root_limit;
        cmd.depth_now   = '0;
        cmd.sender      = own_id;
        cmd.status      = tmrn_pkg::ST_SENT;
        cmd.count       = fan_eff;
      end
    end else begin
      cmd.mismatch = (target_node != own_id);
      case (message_kind)
        tmrn_pkg::MSG_MAP: begin
          if (depth_now == depth_limit - tmrn_pkg::DEPTH_WIDTH'(1)) begin
            cmd.kind   = tmrn_pkg::OUT_REDUCE;
            cmd.base   = sender_node;
            cmd.status = tmrn_pkg::ST_SENT;
          end else begin
            parent_node_next = sender_node;
            cmd.kind         = tmrn_pkg::OUT_MAP;
            cmd.base         = child_base;
            cmd.depth_limit  = depth_limit;
            cmd.depth_now    = depth_now + tmrn_pkg::DEPTH_WIDTH'(1);
            cmd.sender       = own_id;
            cmd.status       = tmrn_pkg::ST_SENT;
            cmd.count        = fan_eff;
          end
        end
        tmrn_pkg::MSG_REDUCE: begin
          answers_seen_next = answers_seen + tmrn_pkg::FAN_WIDTH'(1);
          if (answers_seen_next == fan_eff) begin
            finished_next = 1'b1;
            if (parent_node != '0) begin
              cmd.kind   = tmrn_pkg::OUT_REDUCE;
              cmd.base   = parent_node;
              cmd.status = tmrn_pkg::ST_SENT;
            end
          end
        end
        default: begin
          cmd.status = tmrn_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id       <= tmrn_pkg::ROOT_ID;
      fan_out      <= tmrn_pkg::FAN_WIDTH'(4);
      root_limit   <= tmrn_pkg::DEPTH_WIDTH'(3);
      parent_node  <= '0;
      answers_seen <= '0;
      finished     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tmrn_pkg::REG_OWN_ID:     own_id     <= cfg_data;
          tmrn_pkg::REG_FAN_OUT:    fan_out    <= cfg_data[tmrn_pkg::FAN_WIDTH-1:0];
          tmrn_pkg::REG_ROOT_DEPTH: root_limit <= cfg_data[tmrn_pkg::DEPTH_WIDTH-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        parent_node  <= parent_node_next;
        answers_seen <= answers_seen_next;
        finished     <= finished_next;
      end
    end
  end

endmodule

// File: sv/tmrn_queue.sv
// ----------------------------------------------------------------------------
// tmrn_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tmrn_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmrn_pkg::cmd_t push_cmd,
  input  logic           pop,
  output tmrn_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);

  tmrn_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: sv/tmrn_back.sv
// ----------------------------------------------------------------------------
// tmrn_back
// Expands each command into its run of results, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module tmrn_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  tmrn_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [tmrn_pkg::ID_WIDTH-1:0]      out_target,
  output logic [tmrn_pkg::DEPTH_WIDTH-1:0]   out_depth_limit,
  output logic [tmrn_pkg::DEPTH_WIDTH-1:0]   out_depth_now,
  output logic [tmrn_pkg::ID_WIDTH-1:0]      out_sender,
  output logic [1:0]                         status,
  output logic                               dest_mismatch,
  output logic                               last
);

  tmrn_pkg::cmd_t                 cur;
  logic                           cur_valid;
  logic [tmrn_pkg::IDX_WIDTH-1:0] idx;
  logic                           advance;
  logic                           at_last;
  logic                           cur_done;
  logic                           load;

  assign advance  = cur_valid && (!out_valid || out_ready);
  assign at_last  = ({1'b0, idx} == cur.count - tmrn_pkg::FAN_WIDTH'(1));
  assign cur_done = advance && at_last;
  assign load     = !q_empty && (!cur_valid || cur_done);
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_cmd;
    end
    if (advance) begin
      out_kind        <= cur.kind;
      out_target      <= cur.base + tmrn_pkg::ID_WIDTH'(idx);
      out_depth_limit <= cur.depth_limit;
      out_depth_now   <= cur.depth_now;
      out_sender      <= cur.sender;
      status          <= cur.status;
      dest_mismatch   <= cur.mismatch;
      last            <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (advance) begin
        idx <= idx + tmrn_pkg::IDX_WIDTH'(1);
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/tree_map_reduce_node.sv
// ----------------------------------------------------------------------------
// tree_map_reduce_node
// One node of a tree map/reduce exchange.
//
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes own id,
// fan-out and root depth limit; always ready; write only while idle.
// Input channel (in_valid/in_ready) takes a start command or a received
// message. Output channel (out_valid/out_ready) gives one or more results per
// input; last marks the final one.
// The first result of an item passes through the command queue, the command
// register and the output register before out_valid rises.
// Throughput: one result per cycle from the expansion stage while out_ready
// holds; an item gives one result, or fan-out results (1 to 16) when it spreads maps.
// A two-entry command queue lets the front accept items while the back
// still expands earlier ones.
// Reset: synchronous; restores id 1, fan-out 4, root depth limit 3, clears
// parent, answer count and done flag, and empties queue and output stage.
// Receiver stall: the output register holds; the queue fills, then in_ready
// drops until room frees.
// ----------------------------------------------------------------------------
module tree_map_reduce_node (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmrn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmrn_pkg::ID_WIDTH-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [tmrn_pkg::KIND_WIDTH-1:0]    message_kind,
  input  logic [tmrn_pkg::ID_WIDTH-1:0]      target_node,
  input  logic [tmrn_pkg::DEPTH_WIDTH-1:0]   depth_limit,
  input  logic [tmrn_pkg::DEPTH_WIDTH-1:0]   depth_now,
  input  logic [tmrn_pkg::ID_WIDTH-1:0]      sender_node,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [tmrn_pkg::ID_WIDTH-1:0]      out_target,
  output logic [tmrn_pkg::DEPTH_WIDTH-1:0]   out_depth_limit,
  output logic [tmrn_pkg::DEPTH_WIDTH-1:0]   out_depth_now,
  output logic [tmrn_pkg::ID_WIDTH-1:0]      out_sender,
  output logic [1:0]                         status,
  output logic                               dest_mismatch,
  output logic                               last
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  tmrn_pkg::cmd_t push_cmd;
  tmrn_pkg::cmd_t pop_cmd;

  tmrn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .message_kind (message_kind),
    .target_node  (target_node),
    .depth_limit  (depth_limit),
    .depth_now    (depth_now),
    .sender_node  (sender_node),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  tmrn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  tmrn_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_target      (out_target),
    .out_depth_limit (out_depth_limit),
    .out_depth_now   (out_depth_now),
    .out_sender      (out_sender),
    .status          (status),
    .dest_mismatch   (dest_mismatch),
    .last            (last)
  );

endmodule
